// ===== rtl/core/tpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcc_pkg
// Shared types and constants for the timed path conflict checker: item
// kinds, field widths and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcc_pkg;

	// item kinds
	localparam logic [1:0] KIND_OWN   = 2'd0;
	localparam logic [1:0] KIND_OTHER = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;

	// fixed field widths
	localparam int KIND_W  = 2;
	localparam int STEP_W  = 16;
	localparam int FIELD_W = 8;
	localparam int COUNT_W = 10;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// controller to datapath
	typedef struct packed {
		logic load_own;   // write one site of the own path
		logic load_other; // write one site of the other path
		logic ofs;        // register the start offsets, clear the count
		logic len;        // register the overlap length and start addresses
		logic issue;      // read one aligned pair of sites
		logic emit;       // move the count into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_zero;     // no aligned steps
		logic last_issue; // the current read is the last of the overlap
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/timed_path_conflict_check.sv =====
// ----------------------------------------------------------------------------
// timed_path_conflict_check
// Checks two timed grid paths for vertex and swap conflicts.
// ----------------------------------------------------------------------------
// Load items (kind 0 own path, kind 1 other path) are taken in idle and
// give no result; first_site restarts a path at start_step, and loads past
// MAX_SITES sites are dropped. A check item (kind 2) walks the N time steps
// both paths share, reading one aligned pair of sites per cycle from the two
// path RAMs, and returns the saturated vertex plus swap conflict count and
// a nonzero flag. A check runs through the offset, length, read walk, drain
// and done states, and the block takes no new item until it is back in idle.
// The result sits in an output register, so loads are taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_path_conflict_check #(
	parameter int MAX_SITES  = 256,
	parameter int COORD_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [tpcc_pkg::KIND_W-1:0]       kind,
	input  wire logic                              first_site,
	input  wire logic [tpcc_pkg::STEP_W-1:0]       start_step,
	input  wire logic [tpcc_pkg::FIELD_W-1:0]      row,
	input  wire logic [tpcc_pkg::FIELD_W-1:0]      col,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   collides,
	output logic      [tpcc_pkg::COUNT_W-1:0]      conflict_count
);

	tpcc_pkg::cmd_t    cmd;
	tpcc_pkg::status_t status;

	// sequencing and handshakes
	tpcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// path stores and conflict counting
	tpcc_dp #(
		.MAX_SITES  (MAX_SITES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.first_site     (first_site),
		.start_step     (start_step),
		.row            (row),
		.col            (col),
		.collides       (collides),
		.conflict_count (conflict_count)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tpcc_ram.sv =====
// ----------------------------------------------------------------------------
// tpcc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tpcc_dp.sv =====
// ----------------------------------------------------------------------------
// tpcc_dp
// Datapath of the conflict checker: path stores, lengths and start steps,
// overlap setup, the aligned read walk and the saturating conflict counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcc_dp #(
	parameter int MAX_SITES  = 256,
	parameter int COORD_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tpcc_pkg::cmd_t                    cmd,
	output tpcc_pkg::status_t                      status,
	input  wire logic                              first_site,
	input  wire logic [tpcc_pkg::STEP_W-1:0]       start_step,
	input  wire logic [tpcc_pkg::FIELD_W-1:0]      row,
	input  wire logic [tpcc_pkg::FIELD_W-1:0]      col,
	output logic                                   collides,
	output logic      [tpcc_pkg::COUNT_W-1:0]      conflict_count
);

	localparam int AW = $clog2(MAX_SITES);
	localparam int LW = $clog2(MAX_SITES + 1);
	localparam int CW = 2 * COORD_BITS;
	localparam int SW = tpcc_pkg::STEP_W;
	localparam int NW = tpcc_pkg::COUNT_W;

	logic [LW-1:0] own_len_q, oth_len_q;
	logic [SW-1:0] own_start_q, oth_start_q;
	logic [SW-1:0] p_q, q_q;
	logic [LW-1:0] n_q, i_q;
	logic [AW-1:0] ap_q, aq_q;
	logic          rvalid_s1, first_s1;
	logic [CW-1:0] prev_own_q, prev_oth_q;
	logic [NW-1:0] count_q, out_count_q;

	logic [CW-1:0] site_word;
	logic [LW-1:0] own_eff, oth_eff;
	logic          own_we, oth_we;
	logic [CW-1:0] own_rd, oth_rd;
	logic          own_ok, oth_ok;
	logic [LW-1:0] own_rem, oth_rem, n_next;
	logic [1:0]    inc;
	logic [NW:0]   sum;

	// packed site from the masked coordinates
	assign site_word = {COORD_BITS'(row), COORD_BITS'(col)};

	// fill position, restarted by a first site
	assign own_eff = first_site ? '0 : own_len_q;
	assign oth_eff = first_site ? '0 : oth_len_q;
	assign own_we  = cmd.load_own && (own_eff != LW'(MAX_SITES));
	assign oth_we  = cmd.load_other && (oth_eff != LW'(MAX_SITES));

	tpcc_ram #(.WIDTH(CW), .DEPTH(MAX_SITES)) u_own_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_eff[AW-1:0]),
		.wdata (site_word),
		.re    (cmd.issue),
		.raddr (ap_q),
		.rdata (own_rd)
	);

	tpcc_ram #(.WIDTH(CW), .DEPTH(MAX_SITES)) u_oth_ram (
		.clk   (clk),
		.we    (oth_we),
		.waddr (oth_eff[AW-1:0]),
		.wdata (site_word),
		.re    (cmd.issue),
		.raddr (aq_q),
		.rdata (oth_rd)
	);

	// path lengths and start steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_len_q   <= '0;
			oth_len_q   <= '0;
			own_start_q <= '0;
			oth_start_q <= '0;
		end else begin
			if (cmd.load_own) begin
				if (first_site) begin
					own_start_q <= start_step;
				end
				own_len_q <= own_we ? LW'(own_eff + 1'b1) : own_eff;
			end
			if (cmd.load_other) begin
				if (first_site) begin
					oth_start_q <= start_step;
				end
				oth_len_q <= oth_we ? LW'(oth_eff + 1'b1) : oth_eff;
			end
		end
	end

	// overlap length from the registered offsets
	assign own_ok  = p_q < SW'(own_len_q);
	assign oth_ok  = q_q < SW'(oth_len_q);
	assign own_rem = LW'(SW'(own_len_q) - p_q);
	assign oth_rem = LW'(SW'(oth_len_q) - q_q);
	always_comb begin
		if (!own_ok || !oth_ok) begin
			n_next = '0;
		end else if (own_rem < oth_rem) begin
			n_next = own_rem;
		end else begin
			n_next = oth_rem;
		end
	end

	// offsets, walk counters and addresses
	always_ff @(posedge clk) begin
		if (cmd.ofs) begin
			if (oth_start_q >= own_start_q) begin
				p_q <= oth_start_q - own_start_q;
				q_q <= '0;
			end else begin
				p_q <= '0;
				q_q <= own_start_q - oth_start_q;
			end
		end
		if (cmd.len) begin
			n_q  <= n_next;
			i_q  <= '0;
			ap_q <= AW'(p_q);
			aq_q <= AW'(q_q);
		end else if (cmd.issue) begin
			i_q  <= LW'(i_q + 1'b1);
			ap_q <= AW'(ap_q + 1'b1);
			aq_q <= AW'(aq_q + 1'b1);
		end
	end

	assign status.n_zero     = (n_q == '0);
	assign status.last_issue = (LW'(i_q + 1'b1) == n_q);

	// read data valid flag for the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			first_s1 <= (i_q == '0);
		end
	end

	// vertex conflict at this step, swap conflict across the previous step
	always_comb begin
		inc = '0;
		if (rvalid_s1) begin
			inc = {1'b0, own_rd == oth_rd}
				+ {1'b0, !first_s1 && (prev_own_q == oth_rd) && (own_rd == prev_oth_q)};
		end
	end

	assign sum = (NW+1)'(count_q) + (NW+1)'(inc);

	// saturating count and previous pair
	always_ff @(posedge clk) begin
		if (cmd.ofs) begin
			count_q <= '0;
		end else if (rvalid_s1) begin
			count_q <= sum[NW] ? tpcc_pkg::COUNT_MAX : sum[NW-1:0];
		end
		if (rvalid_s1) begin
			prev_own_q <= own_rd;
			prev_oth_q <= oth_rd;
		end
		if (cmd.emit) begin
			out_count_q <= count_q;
		end
	end

	assign conflict_count = out_count_q;
	assign collides       = (out_count_q != '0);

endmodule

`default_nettype wire

// ===== rtl/core/tpcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpcc_ctrl
// Controller of the conflict checker: input handshake, sequencing of the
// check (offsets, overlap length, read walk, drain) and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcc_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [tpcc_pkg::KIND_W-1:0]     kind,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output tpcc_pkg::cmd_t                       cmd,
	input  wire tpcc_pkg::status_t               status
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OFS   = 3'd1;
	localparam logic [2:0] S_LEN   = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q, state_next;
	logic       out_valid_q;
	logic       in_xfer, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (kind)
						tpcc_pkg::KIND_OWN:   cmd.load_own = 1'b1;
						tpcc_pkg::KIND_OTHER: cmd.load_other = 1'b1;
						tpcc_pkg::KIND_CHECK: state_next = S_OFS;
						default: ;
					endcase
				end
			end
			S_OFS: begin
				cmd.ofs    = 1'b1;
				state_next = S_LEN;
			end
			S_LEN: begin
				cmd.len    = 1'b1;
				state_next = S_RUN;
			end
			S_RUN: begin
				if (status.n_zero) begin
					state_next = S_DRAIN;
				end else begin
					cmd.issue = 1'b1;
					if (status.last_issue) begin
						state_next = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_next = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.emit   = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
